// ===== hdl/pen_pressure_conditioner_defines.svh =====
`ifndef PEN_PRESSURE_CONDITIONER_DEFINES_SVH
`define PEN_PRESSURE_CONDITIONER_DEFINES_SVH

`ifndef SYNTHESIS
// immediate implication: ante holds -> cons holds in the same cycle
`define PPC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("ppc check failed");
// next-cycle implication
`define PPC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("ppc check failed");
`else
`define PPC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define PPC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

// ===== hdl/ppc_pkg.sv =====
package ppc_pkg;

	localparam logic [1:0] ACT_PACKET = 2'd0;
	localparam logic [1:0] ACT_ENTER  = 2'd1;
	localparam logic [1:0] ACT_LEAVE  = 2'd2;

	localparam logic REG_PMIN = 1'b0;
	localparam logic REG_PMAX = 1'b1;

	localparam logic [15:0] PMIN_RESET = 16'd0;
	localparam logic [15:0] PMAX_RESET = 16'd1023;

	localparam logic [15:0] FULL_SCALE      = 16'h8000;
	localparam logic [14:0] ALPHA_Q15       = 15'd21299;
	localparam logic [13:0] ONE_MINUS_ALPHA = 14'd11469;
	localparam logic [30:0] HALF_LSB        = 31'd16384;
	localparam logic [6:0]  THRESH_FLOOR    = 7'd3;
	localparam int          DIV_STEPS       = 15;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [1:0] {
		KIND_PACKET,
		KIND_ENTER,
		KIND_LEAVE
	} ev_kind_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SETUP,
		B_DIV,
		B_MUL,
		B_EMA,
		B_EMIT
	} back_state_t;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [15:0]        raw_pressure;
		logic [15:0]        button_bits;
		logic               queue_error;
		logic [31:0]        report_time;
		logic               has_metadata;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] sample_x;
		logic signed [31:0] sample_y;
		logic [15:0]        smoothed_level;
		logic [2:0]         button_mask;
		logic [31:0]        sample_time;
		logic               time_valid;
		logic [31:0]        overflow_total;
		logic [31:0]        sample_number;
	} sample_t;

	typedef struct packed {
		ev_kind_t           kind;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [15:0]        raw;
		logic [2:0]         btn;
		logic               ovf_hit;
		logic [31:0]        stamp;
		logic               meta;
	} q_entry_t;

	typedef struct packed {
		logic [FIFO_AW:0] count;
		logic             full;
		logic             empty;
	} fifo_status_t;

	typedef struct packed {
		logic load;
		logic emitting;
	} back_status_t;

endpackage

// ===== hdl/ppc_fifo.sv =====
module ppc_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  ppc_pkg::q_entry_t      wr_entry,
	input  logic                   pop,
	output ppc_pkg::q_entry_t      rd_entry,
	output ppc_pkg::fifo_status_t  status
);
	import ppc_pkg::*;

	q_entry_t             mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rd_entry     = mem[rd_ptr_q];
	assign status.count = count_q;
	assign status.full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign status.empty = (count_q == '0);

endmodule

// ===== hdl/ppc_front.sv =====
module ppc_front (
	input  logic                 item_valid,
	output logic                 item_stall,
	input  ppc_pkg::in_item_t    item,
	input  logic                 fifo_full,
	output logic                 push,
	output ppc_pkg::q_entry_t    entry
);
	import ppc_pkg::*;

	logic known;

	always_comb begin
		known = 1'b1;
		entry.kind = KIND_PACKET;
		case (item.action)
			ACT_PACKET: entry.kind = KIND_PACKET;
			ACT_ENTER:  entry.kind = KIND_ENTER;
			ACT_LEAVE:  entry.kind = KIND_LEAVE;
			default:    known = 1'b0;
		endcase
		entry.pos_x   = item.pos_x;
		entry.pos_y   = item.pos_y;
		entry.raw     = item.raw_pressure;
		entry.btn     = item.button_bits[2:0];
		entry.ovf_hit = item.has_metadata & item.queue_error;
		entry.stamp   = item.has_metadata ? item.report_time : 32'd0;
		entry.meta    = item.has_metadata;
	end

	// unused action codes are taken and dropped
	assign item_stall = fifo_full;
	assign push       = item_valid && !fifo_full && known;

endmodule

// ===== hdl/ppc_back.sv =====
module ppc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [15:0]           cfg_data,
	input  logic                  fifo_empty,
	input  ppc_pkg::q_entry_t     rd_entry,
	output logic                  pop,
	output logic                  sample_valid,
	input  logic                  sample_stall,
	output ppc_pkg::sample_t      sample,
	output ppc_pkg::back_status_t status
);
	import ppc_pkg::*;

	back_state_t state_q, state_d;

	logic [15:0] pmin_q, pmax_q;
	logic        contact_q;
	logic [15:0] ema_q;
	logic [31:0] ovf_q, serial_q;
	logic [31:0] last_x_q, last_y_q;

	q_entry_t    cur_q;
	logic [15:0] span_q, rem_q, norm_q, level_q;
	logic [2:0]  btn_q;
	logic [3:0]  cnt_q;
	logic [29:0] prod_q;

	logic        sample_valid_q;
	sample_t     sample_q;

	logic        pos;
	logic [15:0] diff, span_c;
	logic [6:0]  thresh;
	logic        engaged_n, rest, full_norm;
	logic [16:0] div_t, div_sub;
	logic        div_ge;
	logic [29:0] prod_c, prod_b;
	logic [30:0] acc;
	logic [15:0] level_c;
	logic [31:0] ovf_next, serial_next;
	logic        load;

	assign pos       = cur_q.raw > pmin_q;
	assign diff      = cur_q.raw - pmin_q;
	assign span_c    = (pmax_q > pmin_q) ? (pmax_q - pmin_q) : 16'd1;
	assign thresh    = (span_c[15:9] < THRESH_FLOOR) ? THRESH_FLOOR : span_c[15:9];
	assign engaged_n = contact_q ? pos : (pos && (diff > {9'd0, thresh}));
	assign rest      = !engaged_n && !pos;
	assign full_norm = diff >= span_c;

	assign div_t   = {rem_q, 1'b0};
	assign div_sub = div_t - {1'b0, span_q};
	assign div_ge  = div_t >= {1'b0, span_q};

	assign prod_c  = 30'(ALPHA_Q15) * 30'(norm_q);
	assign prod_b  = 30'(ONE_MINUS_ALPHA) * 30'(ema_q);
	assign acc     = {1'b0, prod_q} + {1'b0, prod_b} + HALF_LSB;
	assign level_c = (acc[30:15] > FULL_SCALE) ? FULL_SCALE : acc[30:15];

	assign ovf_next    = (cur_q.ovf_hit && ovf_q != '1) ? ovf_q + 32'd1 : ovf_q;
	assign serial_next = serial_q + 32'd1;

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		load    = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!fifo_empty) begin
					pop = 1'b1;
					case (rd_entry.kind)
						KIND_PACKET: state_d = B_SETUP;
						KIND_LEAVE:  state_d = B_EMIT;
						default:     state_d = B_IDLE;
					endcase
				end
			end
			B_SETUP: begin
				if (rest) begin
					state_d = B_EMIT;
				end else if (full_norm) begin
					state_d = B_MUL;
				end else begin
					state_d = B_DIV;
				end
			end
			B_DIV: begin
				if (cnt_q == 4'd1) begin
					state_d = B_MUL;
				end
			end
			B_MUL: begin
				if (ema_q == '0 && norm_q != '0) begin
					state_d = B_EMIT;
				end else begin
					state_d = B_EMA;
				end
			end
			B_EMA: state_d = B_EMIT;
			B_EMIT: begin
				if (!sample_valid_q || !sample_stall) begin
					load    = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= B_IDLE;
			pmin_q         <= PMIN_RESET;
			pmax_q         <= PMAX_RESET;
			contact_q      <= 1'b0;
			ema_q          <= '0;
			ovf_q          <= '0;
			serial_q       <= '0;
			last_x_q       <= '0;
			last_y_q       <= '0;
			sample_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_PMIN: pmin_q <= cfg_data;
					REG_PMAX: pmax_q <= cfg_data;
					default:  pmin_q <= pmin_q;
				endcase
			end
			case (state_q)
				B_IDLE: begin
					if (pop && rd_entry.kind != KIND_PACKET) begin
						contact_q <= 1'b0;
						ema_q     <= '0;
					end
				end
				B_SETUP: begin
					contact_q <= engaged_n;
					if (rest) begin
						ema_q <= '0;
					end
				end
				B_MUL: begin
					if (ema_q == '0 && norm_q != '0) begin
						ema_q <= norm_q;
					end
				end
				B_EMA: ema_q <= level_c;
				default: ;
			endcase
			if (load) begin
				serial_q <= serial_next;
				if (cur_q.kind == KIND_PACKET) begin
					ovf_q    <= ovf_next;
					last_x_q <= cur_q.pos_x;
					last_y_q <= cur_q.pos_y;
				end
			end
			if (load) begin
				sample_valid_q <= 1'b1;
			end else if (!sample_stall) begin
				sample_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (pop) begin
					cur_q <= rd_entry;
				end
			end
			B_SETUP: begin
				btn_q  <= cur_q.btn | {2'b00, engaged_n};
				span_q <= span_c;
				rem_q  <= diff;
				cnt_q  <= 4'(DIV_STEPS);
				if (rest) begin
					level_q <= '0;
				end
				norm_q <= full_norm ? FULL_SCALE : 16'd0;
			end
			B_DIV: begin
				rem_q  <= div_ge ? div_sub[15:0] : div_t[15:0];
				norm_q <= {norm_q[14:0], div_ge};
				cnt_q  <= cnt_q - 4'd1;
			end
			B_MUL: begin
				level_q <= norm_q;
				prod_q  <= prod_c;
			end
			B_EMA: level_q <= level_c;
			default: ;
		endcase
		if (load) begin
			if (cur_q.kind == KIND_PACKET) begin
				sample_q.sample_x       <= cur_q.pos_x;
				sample_q.sample_y       <= cur_q.pos_y;
				sample_q.smoothed_level <= level_q;
				sample_q.button_mask    <= btn_q;
				sample_q.sample_time    <= cur_q.stamp;
				sample_q.time_valid     <= cur_q.meta;
				sample_q.overflow_total <= ovf_next;
			end else begin
				sample_q.sample_x       <= last_x_q;
				sample_q.sample_y       <= last_y_q;
				sample_q.smoothed_level <= '0;
				sample_q.button_mask    <= '0;
				sample_q.sample_time    <= '0;
				sample_q.time_valid     <= 1'b0;
				sample_q.overflow_total <= ovf_q;
			end
			sample_q.sample_number <= serial_next;
		end
	end

	assign sample_valid    = sample_valid_q;
	assign sample          = sample_q;
	assign status.load     = load;
	assign status.emitting = (state_q == B_EMIT);

endmodule

// ===== hdl/pen_pressure_conditioner.sv =====
// channel | dir | handshake            | payload
// item    | in  | item_valid/stall     | in_item_t (pen packet, enter, leave)
// sample  | out | sample_valid/stall   | sample_t
// cfg     | in  | cfg_we, no wait      | cfg_index, cfg_data
//
// Packet: setup, the 15-step restoring divider for the normalised pressure,
// multiply, smoothing and emit; a fresh contact skips the smoothing step,
// full-scale pressure skips the divide, a released pen goes straight to emit.
// Leave goes straight to emit. Enter makes no sample.
// Reset clears contact, smoothing, counters and last position; range regs
// return to 0 and 1023. A 2-entry queue keeps items flowing while the
// output register waits on sample_stall.
`include "pen_pressure_conditioner_defines.svh"

module pen_pressure_conditioner (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               item_valid,
	output logic               item_stall,
	input  ppc_pkg::in_item_t  item,
	output logic               sample_valid,
	input  logic               sample_stall,
	output ppc_pkg::sample_t   sample
);
	import ppc_pkg::*;

	logic         push, pop;
	q_entry_t     wr_entry, rd_entry;
	fifo_status_t fst;
	back_status_t bst;

	ppc_front u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.fifo_full  (fst.full),
		.push       (push),
		.entry      (wr_entry)
	);

	ppc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.status   (fst)
	);

	ppc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fifo_empty   (fst.empty),
		.rd_entry     (rd_entry),
		.pop          (pop),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.status       (bst)
	);

	`PPC_ASSERT_IMP(a_fifo_bound, clk, arst_n, 1'b1, fst.count <= (FIFO_AW+1)'(FIFO_DEPTH))
	`PPC_ASSERT_IMP(a_level_range, clk, arst_n, sample_valid, sample.smoothed_level <= FULL_SCALE)
	`PPC_ASSERT_NXT(a_load_shows, clk, arst_n, bst.load, sample_valid)
	`PPC_ASSERT_NXT(a_emit_free, clk, arst_n, bst.emitting && !sample_valid, !bst.emitting)

endmodule

// ===== tb/pen_pressure_conditioner_tb.sv =====
`timescale 1ns / 1ps

module pen_pressure_conditioner_tb;

	import ppc_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int Q15_ONE      = 32768;
	localparam int EMA_NEW      = 21299;
	localparam int EMA_OLD      = 11469;
	localparam int EMA_ROUND    = 16384;
	localparam int THR_DIV      = 512;
	localparam int THR_MIN      = 3;
	localparam int MAX_GAP      = 12;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_OFF     = 400;
	localparam int STALL_LIMIT  = 5000;
	localparam int PHASES       = 6;
	localparam int PER_PHASE    = 260;
	localparam int MAX_PRINTS   = 150;

	typedef struct {
		bit          is_cfg;
		bit          known;
		logic        sel;
		logic [15:0] val;
		in_item_t    it;
		sample_t     want;
	} plan_row_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     cfg_we;
	logic     cfg_index;
	logic [15:0] cfg_data;
	logic     item_valid;
	logic     item_stall;
	in_item_t item;
	logic     sample_valid;
	logic     sample_stall;
	sample_t  sample;

	// predictor state
	logic [15:0] pmin_r, pmax_r;
	bit          engaged;
	logic [15:0] ema_q;
	logic [31:0] ovf_q, serial_q;
	logic signed [31:0] last_x_q, last_y_q;

	sample_t   pending_samples[$];
	plan_row_t plan[$];
	sample_t   want_s;

	bit gaps_on = 1'b1;
	int hold_cycles = 0;
	int errors = 0;
	int idle_run = 0;
	int n_items = 0, n_enter = 0, n_leave = 0, n_ignored = 0;
	int n_samples = 0, n_contact = 0, n_settings = 0;

	pen_pressure_conditioner uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample)
	);

	always #2 clk = ~clk;

	function automatic bit next_sample(input in_item_t it, output sample_t s);
		int span, diff, thr;
		longint q;
		int unsigned norm, lvl;
		logic [2:0] btn;
		s = '0;
		case (it.action)
			ACT_ENTER: begin
				engaged = 1'b0;
				ema_q = '0;
				return 1'b0;
			end
			ACT_LEAVE: begin
				engaged = 1'b0;
				ema_q = '0;
				serial_q++;
				s.sample_x = last_x_q;
				s.sample_y = last_y_q;
				s.overflow_total = ovf_q;
				s.sample_number = serial_q;
				return 1'b1;
			end
			ACT_PACKET: begin
				span = int'(pmax_r) - int'(pmin_r);
				diff = int'(it.raw_pressure) - int'(pmin_r);
				if (span < 1)
					span = 1;
				norm = 0;
				if (diff > 0) begin
					q = longint'(diff) * Q15_ONE / longint'(span);
					norm = (q > Q15_ONE) ? 32'(Q15_ONE) : 32'(q);
				end
				btn = it.button_bits[2:0];
				thr = span / THR_DIV;
				if (thr < THR_MIN)
					thr = THR_MIN;
				if (engaged) begin
					if (diff > 0)
						btn[0] = 1'b1;
					else
						engaged = 1'b0;
				end else if (diff > thr) begin
					engaged = 1'b1;
					btn[0] = 1'b1;
				end
				if (!engaged && diff <= 0) begin
					lvl = 0;
				end else if (ema_q == 0 && norm > 0) begin
					lvl = norm;
				end else begin
					lvl = (EMA_NEW * norm + EMA_OLD * ema_q + EMA_ROUND) >> 15;
					if (lvl > Q15_ONE)
						lvl = Q15_ONE;
				end
				ema_q = lvl[15:0];
				if (it.has_metadata && it.queue_error && ovf_q != 32'hFFFF_FFFF)
					ovf_q++;
				last_x_q = it.pos_x;
				last_y_q = it.pos_y;
				serial_q++;
				s.sample_x = it.pos_x;
				s.sample_y = it.pos_y;
				s.smoothed_level = lvl[15:0];
				s.button_mask = btn;
				s.sample_time = it.has_metadata ? it.report_time : '0;
				s.time_valid = it.has_metadata;
				s.overflow_total = ovf_q;
				s.sample_number = serial_q;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [15:0] clamp16(input int v);
		return (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : 16'(v);
	endfunction

	// pressures around the engage threshold of the current range
	function automatic logic [15:0] near_edge();
		int span, thr;
		span = int'(pmax_r) - int'(pmin_r);
		if (span < 1)
			span = 1;
		thr = span / THR_DIV;
		if (thr < THR_MIN)
			thr = THR_MIN;
		return clamp16(int'(pmin_r) + int'($urandom_range(0, thr + 4)) - 2);
	endfunction

	function automatic logic [15:0] pick_raw();
		case ($urandom_range(0, 7))
			0: return 16'($urandom);
			1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			2: return near_edge();
			default: begin
				if (pmax_r > pmin_r)
					return pmin_r + 16'($urandom_range(0, pmax_r - pmin_r));
				return 16'($urandom);
			end
		endcase
	endfunction

	function automatic in_item_t mk_item(input logic [1:0] act, input logic [15:0] raw);
		in_item_t it;
		it.action = act;
		it.pos_x = $urandom;
		it.pos_y = $urandom;
		it.raw_pressure = raw;
		it.button_bits = 16'($urandom);
		it.queue_error = 1'($urandom_range(0, 1));
		it.report_time = $urandom;
		it.has_metadata = $urandom_range(0, 3) != 0;
		return it;
	endfunction

	function automatic void add_item(input in_item_t it, input bit known = 1'b0,
		input sample_t want = '0);
		plan_row_t r;
		r.is_cfg = 1'b0;
		r.known = known;
		r.sel = REG_PMIN;
		r.val = '0;
		r.it = it;
		r.want = want;
		plan.insert(plan.size(), r);
	endfunction

	function automatic void add_cfg(input logic sel, input logic [15:0] val);
		plan_row_t r;
		r.is_cfg = 1'b1;
		r.known = 1'b0;
		r.sel = sel;
		r.val = val;
		r.it = '0;
		r.want = '0;
		plan.insert(plan.size(), r);
	endfunction

	task automatic flag(input string fld, input logic [63:0] got, input logic [63:0] want);
		if (errors < MAX_PRINTS)
			$display("[%0t] sample %0d %s: got %0h, expected %0h", $time, n_samples, fld,
				got, want);
		errors++;
	endtask

	task automatic send(input in_item_t it, input bit known = 1'b0, input sample_t want = '0);
		int gap;
		sample_t s;
		bit got;
		gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item = it;
		item_valid = 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		got = next_sample(it, s);
		if (got)
			pending_samples.insert(pending_samples.size(), known ? want : s);
		n_items++;
		case (it.action)
			ACT_ENTER: n_enter++;
			ACT_LEAVE: n_leave++;
			ACT_PACKET: if (engaged) n_contact++;
			default: n_ignored++;
		endcase
		@(negedge clk);
	endtask

	task automatic wait_drained();
		item_valid = 1'b0;
		while (pending_samples.size() != 0)
			@(negedge clk);
	endtask

	// enter and ignored items leave no sample behind, so give the block time to finish them
	task automatic write_reg(input logic sel, input logic [15:0] val);
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = sel;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (sel == REG_PMIN)
			pmin_r = val;
		else
			pmax_r = val;
	endtask

	// receiver
	initial begin
		int n;
		sample_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_cycles > 0) begin
				sample_stall = 1'b1;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end
			n = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
			if (n > 0) begin
				sample_stall = 1'b1;
				repeat (n) @(negedge clk);
			end
			sample_stall = 1'b0;
			do @(posedge clk); while (sample_valid !== 1'b1 && hold_cycles == 0);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && sample_valid === 1'b1 && sample_stall === 1'b0) begin
			if (pending_samples.size() == 0) begin
				flag("unexpected transfer, number", sample.sample_number, 0);
			end else begin
				want_s = pending_samples.pop_front();
				n_samples++;
				if (sample.sample_x !== want_s.sample_x)
					flag("sample_x", sample.sample_x, want_s.sample_x);
				if (sample.sample_y !== want_s.sample_y)
					flag("sample_y", sample.sample_y, want_s.sample_y);
				if (sample.smoothed_level !== want_s.smoothed_level)
					flag("smoothed_level", sample.smoothed_level, want_s.smoothed_level);
				if (sample.button_mask !== want_s.button_mask)
					flag("button_mask", sample.button_mask, want_s.button_mask);
				if (sample.sample_time !== want_s.sample_time)
					flag("sample_time", sample.sample_time, want_s.sample_time);
				if (sample.time_valid !== want_s.time_valid)
					flag("time_valid", sample.time_valid, want_s.time_valid);
				if (sample.overflow_total !== want_s.overflow_total)
					flag("overflow_total", sample.overflow_total, want_s.overflow_total);
				if (sample.sample_number !== want_s.sample_number)
					flag("sample_number", sample.sample_number, want_s.sample_number);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (sample_valid && !sample_stall))
			idle_run = 0;
		else
			idle_run++;
		if (idle_run >= STALL_LIMIT) begin
			$display("no transfer for %0d cycles, %0d samples outstanding", idle_run,
				pending_samples.size());
			$display("FAIL pen_pressure_conditioner");
			$finish;
		end
	end

	initial begin
		in_item_t it;
		int done, len;
		logic [1:0] act;
		logic [15:0] raw, lo, hi;
		bit paused;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PMIN;
		cfg_data = '0;
		item_valid = 1'b0;
		item = '0;
		pmin_r = PMIN_RESET;
		pmax_r = PMAX_RESET;
		engaged = 1'b0;
		ema_q = '0;
		ovf_q = '0;
		serial_q = '0;
		last_x_q = '0;
		last_y_q = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// leave straight after reset reports the cleared position
		add_item(mk_item(ACT_LEAVE, 16'h1234), 1'b1, '{sample_x: '0, sample_y: '0,
			smoothed_level: '0, button_mask: '0, sample_time: '0, time_valid: 1'b0,
			overflow_total: '0, sample_number: 32'd1});
		it = mk_item(ACT_PACKET, 16'd0);
		it.pos_x = 32'sh8000_0000;
		it.pos_y = 32'sh7FFF_FFFF;
		it.button_bits = 16'hFFFF;
		it.queue_error = 1'b1;
		it.has_metadata = 1'b1;
		it.report_time = 32'hFFFF_FFFF;
		add_item(it, 1'b1, '{sample_x: 32'sh8000_0000, sample_y: 32'sh7FFF_FFFF,
			smoothed_level: '0, button_mask: 3'b111, sample_time: 32'hFFFF_FFFF,
			time_valid: 1'b1, overflow_total: 32'd1, sample_number: 32'd2});
		// queue error without metadata is not counted
		it = mk_item(ACT_PACKET, 16'd3);
		it.queue_error = 1'b1;
		it.has_metadata = 1'b0;
		it.button_bits = 16'h0000;
		add_item(it);
		add_item(mk_item(ACT_PACKET, 16'd4));
		add_item(mk_item(ACT_PACKET, 16'hFFFF));
		add_item(mk_item(ACT_PACKET, 16'hFFFF));
		add_item(mk_item(ACT_PACKET, 16'd1));
		add_item(mk_item(ACT_PACKET, 16'd0));
		add_item(mk_item(ACT_PACKET, 16'd500));
		add_item(mk_item(ACT_ENTER, 16'd0));
		add_item(mk_item(ACT_UNUSED, 16'd700));
		add_item(mk_item(ACT_PACKET, 16'd500));
		add_item(mk_item(ACT_LEAVE, 16'd0));
		// inverted range
		add_cfg(REG_PMIN, 16'hFFFF);
		add_cfg(REG_PMAX, 16'h0000);
		add_item(mk_item(ACT_PACKET, 16'hFFFF));
		add_item(mk_item(ACT_PACKET, 16'd0));
		// empty range, span of one
		add_cfg(REG_PMIN, 16'd100);
		add_cfg(REG_PMAX, 16'd100);
		add_item(mk_item(ACT_PACKET, 16'd103));
		add_item(mk_item(ACT_PACKET, 16'd104));
		add_item(mk_item(ACT_PACKET, 16'd101));
		add_item(mk_item(ACT_PACKET, 16'd100));
		// full range, threshold of 127
		add_cfg(REG_PMIN, 16'd0);
		add_cfg(REG_PMAX, 16'hFFFF);
		add_item(mk_item(ACT_PACKET, 16'd127));
		add_item(mk_item(ACT_PACKET, 16'd128));
		add_item(mk_item(ACT_PACKET, 16'hFFFF));
		add_item(mk_item(ACT_LEAVE, 16'd0));

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].sel, plan[i].val);
			else
				send(plan[i].it, plan[i].known, plan[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin lo = 16'd0; hi = 16'hFFFF; end
				1: begin lo = 16'hFFFF; hi = 16'd0; end
				2: begin lo = 16'd1000; hi = 16'd1000; end
				3: begin
					lo = 16'($urandom_range(0, 30000));
					hi = lo + 16'($urandom_range(1, 30000));
				end
				4: begin lo = 16'($urandom); hi = 16'($urandom); end
				default: begin lo = 16'd16; hi = 16'd2047; end
			endcase
			write_reg(REG_PMIN, lo);
			write_reg(REG_PMAX, hi);
			n_settings++;
			gaps_on = (p != 2);
			if (p == 3)
				hold_cycles = HOLD_OFF;
			paused = 1'b0;
			done = 0;
			while (done < PER_PHASE) begin
				if (p == 4 && !paused && done >= PER_PHASE / 2) begin
					wait_drained();
					paused = 1'b1;
				end
				if ($urandom_range(0, 9) < 7) begin
					// stroke: optional enter, ramp through contact, lift, optional leave
					if ($urandom_range(0, 1)) begin
						send(mk_item(ACT_ENTER, 16'($urandom)));
						done++;
					end
					len = $urandom_range(1, 20);
					for (int k = 0; k < len; k++) begin
						if (k == len - 1 && len > 2)
							raw = clamp16(int'(pmin_r) - int'($urandom_range(0, 4)));
						else if (k < 2)
							raw = near_edge();
						else
							raw = pick_raw();
						send(mk_item(ACT_PACKET, raw));
						done++;
					end
					if ($urandom_range(0, 4) != 0) begin
						send(mk_item(ACT_LEAVE, 16'($urandom)));
						done++;
					end
				end else begin
					act = 2'($urandom_range(0, 3));
					send(mk_item(act, pick_raw()));
					if (act != ACT_UNUSED)
						done++;
				end
			end
		end

		item_valid = 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d events (%0d enter, %0d leave, %0d ignored) across %0d range setups",
			n_items, n_enter, n_leave, n_ignored, n_settings);
		$display("checked %0d samples, %0d packets in contact, %0d mismatches",
			n_samples, n_contact, errors);
		if (errors == 0)
			$display("PASS pen_pressure_conditioner");
		else
			$display("FAIL pen_pressure_conditioner");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ppc_pkg.sv
hdl/ppc_fifo.sv
hdl/ppc_front.sv
hdl/ppc_back.sv
hdl/pen_pressure_conditioner.sv
tb/pen_pressure_conditioner_tb.sv
